### hw/rtl/hemicube_weighted_irradiance_gather_assert.svh
// Assertion macros used by the gather accumulator.
`ifndef HEMICUBE_WEIGHTED_IRRADIANCE_GATHER_ASSERT_SVH
`define HEMICUBE_WEIGHTED_IRRADIANCE_GATHER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HWIG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HWIG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/hwig_pkg.sv
`default_nettype none

package hwig_pkg;

    // Item modes carried on the input tuser
    localparam logic [1:0] MODE_TOP   = 2'd0;
    localparam logic [1:0] MODE_SIDE  = 2'd1;
    localparam logic [1:0] MODE_PIXEL = 2'd2;

    // Weight table geometry
    localparam int TOP_DEPTH  = 16384;
    localparam int SIDE_DEPTH = 8192;
    localparam int TOP_AW     = 14;
    localparam int SIDE_AW    = 13;

    localparam int W_W    = 24;
    localparam int PROD_W = 48;
    localparam int TOT_W  = 51;
    localparam int CNT_W  = 16;

    localparam logic [PROD_W-1:0] SUM_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX     = 16'hFFFF;
    localparam logic [CNT_W-1:0]  LIMIT_RESET = 16'd4915;

    // Pixel group after the weight read
    typedef struct packed {
        logic                     upper;
        logic                     last;
        logic [4:0]               flags;
        logic [4:0][W_W-1:0]      rad;
    } pix_t;

    // Pixel group reduced to one sum and one flag count
    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic [TOT_W-1:0]         total;
        logic [2:0]               nflag;
    } red_t;

endpackage

`default_nettype wire

### hw/rtl/hwig_wmem.sv
`default_nettype none

module hwig_wmem #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while disabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/hwig_mac.sv
`default_nettype none

module hwig_mac (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          adv,
    input  wire logic                          s1_valid,
    input  wire hwig_pkg::pix_t                s1_pix,
    input  wire logic [hwig_pkg::W_W-1:0]      top_w,
    input  wire logic [hwig_pkg::W_W-1:0]      side_w,
    output hwig_pkg::red_t                     red
);

    logic [4:0][hwig_pkg::PROD_W-1:0] prod_reg;
    logic [4:0][hwig_pkg::PROD_W-1:0] prod_next;
    logic [2:0]                       nflag_reg;
    logic [2:0]                       nflag_next;
    logic                             v2_reg;
    logic                             last2_reg;
    logic [hwig_pkg::TOT_W-1:0]       total_reg;
    logic [hwig_pkg::TOT_W-1:0]       total_next;
    logic [2:0]                       nflag3_reg;
    logic                             v3_reg;
    logic                             last3_reg;

    // Multiply each radiance by its weight; side faces only in the upper half
    always_comb begin
        prod_next[0] = hwig_pkg::PROD_W'(top_w) * hwig_pkg::PROD_W'(s1_pix.rad[0]);
        for (int k = 1; k < 5; k++) begin
            prod_next[k] = s1_pix.upper
                ? hwig_pkg::PROD_W'(side_w) * hwig_pkg::PROD_W'(s1_pix.rad[k])
                : '0;
        end
        nflag_next = 3'(s1_pix.flags[0])
                   + (s1_pix.upper ? 3'($countones(s1_pix.flags[4:1])) : 3'd0);
    end

    // Add the five products
    always_comb begin
        total_next = '0;
        for (int k = 0; k < 5; k++) begin
            total_next = total_next + hwig_pkg::TOT_W'(prod_reg[k]);
        end
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= s1_valid;
            v3_reg <= v2_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg   <= prod_next;
            nflag_reg  <= nflag_next;
            last2_reg  <= s1_pix.last;
            total_reg  <= total_next;
            nflag3_reg <= nflag_reg;
            last3_reg  <= last2_reg;
        end
    end

    assign red.valid = v3_reg;
    assign red.last  = last3_reg;
    assign red.total = total_reg;
    assign red.nflag = nflag3_reg;

endmodule

`default_nettype wire

### hw/rtl/hwig_accum.sv
`default_nettype none

`include "hemicube_weighted_irradiance_gather_assert.svh"

module hwig_accum (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire hwig_pkg::red_t                red,
    input  wire logic [hwig_pkg::CNT_W-1:0]    limit,
    output logic                               adv,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [39:0]                        m_tdata,  // irradiance, backface_count
    output logic                               m_tuser   // rejected
);

    logic [hwig_pkg::PROD_W-1:0] sum_reg;
    logic [hwig_pkg::PROD_W-1:0] sum_next;
    logic [hwig_pkg::CNT_W-1:0]  cnt_reg;
    logic [hwig_pkg::CNT_W-1:0]  cnt_next;
    logic [hwig_pkg::PROD_W+3:0] sum_wide;
    logic [hwig_pkg::CNT_W:0]    cnt_wide;
    logic                        out_valid_reg;
    logic [hwig_pkg::W_W-1:0]    irr_reg;
    logic [hwig_pkg::CNT_W-1:0]  ocnt_reg;
    logic                        rej_reg;
    logic                        rej_next;
    logic                        retire_last;

    // Hold the pipeline only when a result must enter a full output register
    assign adv = !(red.valid && red.last && out_valid_reg && !m_tready);
    assign retire_last = adv && red.valid && red.last;

    // Saturating accumulate of sum and flag count
    always_comb begin
        sum_wide = {4'b0, sum_reg} + {1'b0, red.total};
        sum_next = (sum_wide > {4'b0, hwig_pkg::SUM_MAX}) ? hwig_pkg::SUM_MAX
                                                         : sum_wide[hwig_pkg::PROD_W-1:0];
        cnt_wide = {1'b0, cnt_reg} + {14'b0, red.nflag};
        cnt_next = cnt_wide[hwig_pkg::CNT_W] ? hwig_pkg::CNT_MAX
                                            : cnt_wide[hwig_pkg::CNT_W-1:0];
        rej_next = cnt_next > limit;
    end

    // Accumulators, cleared after the last group of a texel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (adv && red.valid) begin
            if (red.last) begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end else begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (retire_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (retire_last) begin
            irr_reg  <= rej_next ? '0 : sum_next[hwig_pkg::PROD_W-1:hwig_pkg::W_W];
            rej_reg  <= rej_next;
            ocnt_reg <= cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {ocnt_reg, irr_reg};
    assign m_tuser  = rej_reg;

    `HWIG_ASSERT_NOW(a_rej_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata[23:0] == 24'd0, "rejected result carries light")
    `HWIG_ASSERT_NOW(a_rej_match, aclk, aresetn, m_tvalid, m_tuser == (m_tdata[39:24] > limit), "reject flag disagrees with count")
    `HWIG_ASSERT_NEXT(a_clear, aclk, aresetn, retire_last, sum_reg == '0 && cnt_reg == '0, "accumulators not cleared after texel")
    `HWIG_ASSERT_NEXT(a_out_load, aclk, aresetn, retire_last, m_tvalid, "finished texel did not reach the output")

endmodule

`default_nettype wire

### hw/rtl/hemicube_weighted_irradiance_gather.sv
// A last pixel group passes the weight read stage, the product and sum registers and the output register.
// Throughput: one item per cycle while s_tready is high; one read of each weight memory per pixel group.
// The input stalls only while a finished texel waits to enter a full output register that is not being read.
// Reset (aresetn low, synchronous) clears the sums, the count, valids and sets the
// back-face limit to 4915; weight memories keep their contents and need no pass.
`default_nettype none

module hemicube_weighted_irradiance_gather #(
    parameter int FACE_SIDE = 128
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // index, weight, front, up, down, left, right radiance, backface_flags, pad
    input  wire logic [167:0] s_tdata,
    input  wire logic [1:0]   s_tuser,   // mode
    input  wire logic         s_tlast,   // last_pixel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,   // irradiance, backface_count
    output logic              m_tuser    // rejected
);

    localparam int unsigned HALF = FACE_SIDE * (FACE_SIDE / 2);
    localparam logic [15:0] HALF_W = 16'(HALF);
    localparam logic [hwig_pkg::SIDE_AW-1:0] HALF_S = hwig_pkg::SIDE_AW'(HALF);

    logic [hwig_pkg::CNT_W-1:0]  limit_reg;
    logic                        adv;
    logic                        accept;
    logic [hwig_pkg::TOP_AW-1:0] idx;
    logic [hwig_pkg::W_W-1:0]    wt;
    logic [hwig_pkg::W_W-1:0]    top_w;
    logic [hwig_pkg::W_W-1:0]    side_w;
    hwig_pkg::pix_t              pix_in;
    hwig_pkg::pix_t              s1_pix_reg;
    logic                        s1_valid_reg;
    hwig_pkg::red_t              red;

    // Unpack the item
    assign idx = s_tdata[13:0];
    assign wt  = s_tdata[37:14];
    always_comb begin
        for (int k = 0; k < 5; k++) begin
            pix_in.rad[k] = s_tdata[38 + 24*k +: 24];
        end
        pix_in.flags = s_tdata[162:158];
        pix_in.last  = s_tlast;
        pix_in.upper = {2'b00, idx} >= HALF_W;
    end

    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // Back-face limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= hwig_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Top-face weights
    hwig_wmem #(
        .WIDTH (24),
        .DEPTH (16384)
    ) u_top_mem (
        .aclk    (aclk),
        .wr_en   (accept && s_tuser == hwig_pkg::MODE_TOP),
        .wr_addr (idx),
        .wr_data (wt),
        .rd_en   (adv),
        .rd_addr (idx),
        .rd_data (top_w)
    );

    // Side-face weights, read at the offset into the upper half
    hwig_wmem #(
        .WIDTH (24),
        .DEPTH (8192)
    ) u_side_mem (
        .aclk    (aclk),
        .wr_en   (accept && s_tuser == hwig_pkg::MODE_SIDE),
        .wr_addr (idx[hwig_pkg::SIDE_AW-1:0]),
        .wr_data (wt),
        .rd_en   (adv),
        .rd_addr (idx[hwig_pkg::SIDE_AW-1:0] - HALF_S),
        .rd_data (side_w)
    );

    // Pixel group stage alongside the weight read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid && s_tuser == hwig_pkg::MODE_PIXEL;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_pix_reg <= pix_in;
        end
    end

    hwig_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .s1_valid (s1_valid_reg),
        .s1_pix   (s1_pix_reg),
        .top_w    (top_w),
        .side_w   (side_w),
        .red      (red)
    );

    hwig_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .red      (red),
        .limit    (limit_reg),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOP_DEPTH  = hwig_pkg::TOP_DEPTH;
    localparam int SIDE_DEPTH = hwig_pkg::SIDE_DEPTH;
    localparam int TOP_AW     = hwig_pkg::TOP_AW;
    localparam int SIDE_AW    = hwig_pkg::SIDE_AW;
    localparam int W_W        = hwig_pkg::W_W;
    localparam int PROD_W     = hwig_pkg::PROD_W;
    localparam int CNT_W      = hwig_pkg::CNT_W;
    localparam logic [PROD_W-1:0] SUM_MAX     = hwig_pkg::SUM_MAX;
    localparam logic [CNT_W-1:0]  CNT_MAX     = hwig_pkg::CNT_MAX;
    localparam logic [CNT_W-1:0]  LIMIT_RESET = hwig_pkg::LIMIT_RESET;
    localparam logic [1:0] MODE_TOP   = hwig_pkg::MODE_TOP;
    localparam logic [1:0] MODE_SIDE  = hwig_pkg::MODE_SIDE;
    localparam logic [1:0] MODE_PIXEL = hwig_pkg::MODE_PIXEL;

    localparam int FACE_SIDE = 128;
    localparam int HALF = FACE_SIDE * (FACE_SIDE / 2);
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [CNT_W-1:0] LIMIT_TOP = 16'd49152;
    localparam int DRAIN_CYCLES = 10;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 195;
    // groups in one long texel sent back to back
    localparam int LONG_GROUPS = 32;

    typedef struct packed {
        logic [1:0]          mode;
        logic [TOP_AW-1:0]   index;
        logic [W_W-1:0]      weight;
        logic [4:0][W_W-1:0] rad;     // front, up, down, left, right from index 0
        logic [4:0]          flags;
        logic                last;
    } gather_item_t;

    typedef struct packed {
        logic [W_W-1:0]   irradiance;
        logic             rejected;
        logic [CNT_W-1:0] backface_count;
    } gather_result_t;

    typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_e;

    typedef struct {
        row_kind_e        kind;
        gather_item_t     item;
        logic [CNT_W-1:0] limit;
        bit               typed;
        gather_result_t   want;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    wire logic           s_tready;
    // index, weight, front, up, down, left, right radiance, backface_flags, pad
    logic [167:0]        s_tdata = '0;
    logic [1:0]          s_tuser = '0;   // mode
    logic                s_tlast = 1'b0; // last_pixel
    wire logic           m_tvalid;
    logic                m_tready = 1'b0;
    wire logic [39:0]    m_tdata;        // irradiance, backface_count
    wire logic           m_tuser;        // rejected

    // Gather model state
    logic [W_W-1:0]      top_w [TOP_DEPTH];
    logic [W_W-1:0]      side_w [SIDE_DEPTH];
    bit                  top_set [TOP_DEPTH];
    bit                  side_set [SIDE_DEPTH];
    logic [PROD_W-1:0]   acc_sum = '0;
    logic [CNT_W-1:0]    acc_cnt = '0;
    logic [CNT_W-1:0]    bf_limit = LIMIT_RESET;
    // positions whose weights are all loaded
    logic [TOP_AW-1:0]   pix_ok [$];

    gather_result_t      texel_q [$];
    gather_result_t      texel_want;
    int                  fails = 0;
    bit                  steady = 1'b0;
    int                  rx_wait = 0;
    int                  rx_next;
    int                  quiet = 0;

    hemicube_weighted_irradiance_gather #(
        .FACE_SIDE(FACE_SIDE)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the gather model by one item; flag a texel result on the last group
    function automatic void gather_predict(input gather_item_t it, output bit emits,
                                           output gather_result_t res);
        logic [SIDE_AW-1:0] six;
        logic [W_W-1:0]     wt;
        logic [PROD_W-1:0]  prod;
        logic [PROD_W:0]    sum;
        bit                 upper;
        int                 f;
        emits = 1'b0;
        res = '0;
        upper = int'(it.index) >= HALF;
        case (it.mode)
            MODE_TOP: begin
                top_w[it.index] = it.weight;
                top_set[it.index] = 1'b1;
                six = SIDE_AW'(int'(it.index) - HALF);
                if (!upper || side_set[six]) begin
                    pix_ok.push_back(it.index);
                end
            end
            MODE_SIDE: begin
                six = it.index[SIDE_AW-1:0];
                side_w[six] = it.weight;
                side_set[six] = 1'b1;
                if (top_set[int'(six) + HALF]) begin
                    pix_ok.push_back(TOP_AW'(int'(six) + HALF));
                end
            end
            MODE_PIXEL: begin
                six = SIDE_AW'(int'(it.index) - HALF);
                for (f = 0; f < 5; f++) begin
                    if (f == 0 || upper) begin
                        wt = (f == 0) ? top_w[it.index] : side_w[six];
                        prod = {24'b0, wt} * {24'b0, it.rad[f]};
                        sum = {1'b0, acc_sum} + {1'b0, prod};
                        acc_sum = sum[PROD_W] ? SUM_MAX : sum[PROD_W-1:0];
                        if (it.flags[f] && acc_cnt != CNT_MAX) begin
                            acc_cnt = acc_cnt + 1'b1;
                        end
                    end
                end
                if (it.last) begin
                    emits = 1'b1;
                    res.rejected = acc_cnt > bf_limit;
                    res.irradiance = res.rejected ? '0 : acc_sum[PROD_W-1:24];
                    res.backface_count = acc_cnt;
                    acc_sum = '0;
                    acc_cnt = '0;
                end
            end
            default: begin
                // unused mode: drop
            end
        endcase
    endfunction

    function automatic gather_item_t make_item(input logic [1:0] mode,
                                               input logic [TOP_AW-1:0] idx,
                                               input logic [W_W-1:0] w,
                                               input logic [W_W-1:0] front,
                                               input logic [W_W-1:0] up,
                                               input logic [W_W-1:0] down,
                                               input logic [W_W-1:0] left,
                                               input logic [W_W-1:0] right,
                                               input logic [4:0] flags,
                                               input logic last);
        gather_item_t it;
        it.mode = mode;
        it.index = idx;
        it.weight = w;
        it.rad = {right, left, down, up, front};
        it.flags = flags;
        it.last = last;
        return it;
    endfunction

    // Favor the ends of the range now and then
    function automatic logic [W_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return {W_W{1'b1}};
        end
        return W_W'($urandom());
    endfunction

    // Drive one item, after a random gap unless steady, then record any expected texel result
    task automatic send_item(input gather_item_t it, input bit typed = 1'b0,
                             input gather_result_t want = '0);
        int             gap;
        bit             emits;
        gather_result_t res;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, it.flags, it.rad, it.weight, it.index};
        s_tuser <= it.mode;
        s_tlast <= it.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gather_predict(it, emits, res);
        if (emits) begin
            texel_q.push_back(typed ? want : res);
        end
    endtask

    // Hold the input until every expected texel result is back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (texel_q.size() != 0) @(posedge aclk);
    endtask

    // Write the back-face limit once the pipeline has emptied
    task automatic write_limit(input logic [CNT_W-1:0] value);
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        bf_limit = value;
    endtask

    // Accept results with random stalls and compare them in order
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (texel_q.size() == 0) begin
                    $error("unexpected result: irradiance %h, rejected %b, backface_count %0d",
                           m_tdata[23:0], m_tuser, m_tdata[39:24]);
                    fails++;
                end else begin
                    texel_want = texel_q.pop_front();
                    if (m_tdata[23:0] !== texel_want.irradiance) begin
                        $error("irradiance: expected %h, actual %h",
                               texel_want.irradiance, m_tdata[23:0]);
                        fails++;
                    end
                    if (m_tuser !== texel_want.rejected) begin
                        $error("rejected: expected %b, actual %b", texel_want.rejected, m_tuser);
                        fails++;
                    end
                    if (m_tdata[39:24] !== texel_want.backface_count) begin
                        $error("backface_count: expected %0d, actual %0d",
                               texel_want.backface_count, m_tdata[39:24]);
                        fails++;
                    end
                end
                rx_next = steady ? 0 : $urandom_range(0, 7);
            end else begin
                rx_next = (rx_wait > 0) ? rx_wait - 1 : 0;
            end
            rx_wait <= rx_next;
            m_tready <= (rx_next == 0);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        stim_row_t    rows [$];
        gather_item_t it;
        int           ph;
        int           sent;
        int           r;
        int           j;
        int           n;
        bit           paused;

        // Directed rows, under the reset limit first
        rows.push_back('{ROW_ITEM, make_item(MODE_TOP, 14'd0, 24'hFFFFFF, '0, '0, '0, '0, '0,
                         5'h00, 1'b0), '0, 1'b0, '0});
        rows.push_back('{ROW_ITEM, make_item(MODE_TOP, 14'h3FFF, 24'hFFFFFF, '0, '0, '0, '0,
                         '0, 5'h00, 1'b0), '0, 1'b0, '0});
        rows.push_back('{ROW_ITEM, make_item(MODE_TOP, 14'd8191, pick_word(), '0, '0, '0, '0,
                         '0, 5'h00, 1'b0), '0, 1'b0, '0});
        rows.push_back('{ROW_ITEM, make_item(MODE_TOP, 14'd8192, 24'h000000, '0, '0, '0, '0,
                         '0, 5'h00, 1'b0), '0, 1'b0, '0});
        rows.push_back('{ROW_ITEM, make_item(MODE_SIDE, 14'd8191, 24'hFFFFFF, '0, '0, '0, '0,
                         '0, 5'h00, 1'b0), '0, 1'b0, '0});
        // side entry 0 through the wrapped index
        rows.push_back('{ROW_ITEM, make_item(MODE_SIDE, 14'd8192, 24'h800000, '0, '0, '0, '0,
                         '0, 5'h00, 1'b0), '0, 1'b0, '0});
        rows.push_back('{ROW_ITEM, make_item(MODE_PIXEL, 14'd0, '0, 24'h000000, '0, '0, '0,
                         '0, 5'h00, 1'b1), '0, 1'b1, '{24'h000000, 1'b0, 16'd0}});
        // lower half counts only the front flag
        rows.push_back('{ROW_ITEM, make_item(MODE_PIXEL, 14'd0, '0, 24'hFFFFFF, 24'hFFFFFF,
                         24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 5'h1F, 1'b1), '0, 1'b1,
                         '{24'hFFFFFE, 1'b0, 16'd1}});
        // drive the sum into saturation
        rows.push_back('{ROW_ITEM, make_item(MODE_PIXEL, 14'h3FFF, '0, 24'hFFFFFF, 24'hFFFFFF,
                         24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 5'h1F, 1'b0), '0, 1'b0, '0});
        rows.push_back('{ROW_ITEM, make_item(MODE_UNUSED, 14'h3FFF, 24'hFFFFFF, 24'hFFFFFF,
                         24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 5'h1F, 1'b1), '0,
                         1'b0, '0});
        rows.push_back('{ROW_ITEM, make_item(MODE_PIXEL, 14'h3FFF, '0, '0, '0, '0, '0, '0,
                         5'h00, 1'b1), '0, 1'b1, '{24'hFFFFFF, 1'b0, 16'd5}});
        rows.push_back('{ROW_ITEM, make_item(MODE_PIXEL, 14'd8192, pick_word(), pick_word(),
                         pick_word(), pick_word(), pick_word(), pick_word(), 5'h1E, 1'b0), '0,
                         1'b0, '0});
        rows.push_back('{ROW_ITEM, make_item(MODE_PIXEL, 14'd8191, pick_word(), pick_word(),
                         pick_word(), pick_word(), pick_word(), pick_word(), 5'h1F, 1'b1), '0,
                         1'b0, '0});
        rows.push_back('{ROW_LIMIT, '0, 16'd0, 1'b0, '0});
        rows.push_back('{ROW_ITEM, make_item(MODE_PIXEL, 14'd0, '0, 24'h000001, '0, '0, '0,
                         '0, 5'h01, 1'b1), '0, 1'b1, '{24'h000000, 1'b1, 16'd1}});
        rows.push_back('{ROW_ITEM, make_item(MODE_PIXEL, 14'd0, '0, 24'hFFFFFF, '0, '0, '0,
                         '0, 5'h00, 1'b1), '0, 1'b1, '{24'hFFFFFE, 1'b0, 16'd0}});
        rows.push_back('{ROW_LIMIT, '0, LIMIT_TOP, 1'b0, '0});
        rows.push_back('{ROW_ITEM, make_item(MODE_PIXEL, 14'h3FFF, pick_word(), pick_word(),
                         pick_word(), pick_word(), pick_word(), pick_word(), 5'h1F, 1'b1), '0,
                         1'b0, '0});

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (rows[k]) begin
            if (rows[k].kind == ROW_LIMIT) begin
                write_limit(rows[k].limit);
            end else begin
                send_item(rows[k].item, rows[k].typed, rows[k].want);
            end
        end

        // One long texel, back to back
        steady = 1'b1;
        for (n = 0; n < LONG_GROUPS; n++) begin
            send_item(make_item(MODE_PIXEL, 14'h3FFF, pick_word(), pick_word(), pick_word(),
                                pick_word(), pick_word(), pick_word(), 5'h1F,
                                n == LONG_GROUPS - 1));
        end
        steady = 1'b0;

        // Random phases, each under its own limit
        paused = 1'b0;
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       write_limit(16'd0);
                1:       write_limit(LIMIT_TOP);
                3, 7:    write_limit(CNT_W'($urandom_range(0, 49152)));
                4:       write_limit(LIMIT_RESET);
                default: write_limit(CNT_W'($urandom_range(1, 40)));
            endcase
            steady = (ph == 2);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (ph == 4 && sent >= PHASE_ITEMS / 2 && !paused) begin
                    paused = 1'b1;
                    wait_results();
                end
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    // noise in the unused mode
                    send_item(make_item(MODE_UNUSED, TOP_AW'($urandom()), pick_word(),
                                        pick_word(), pick_word(), pick_word(), pick_word(),
                                        pick_word(), 5'($urandom()), 1'($urandom())));
                end else if (r < 10) begin
                    send_item(make_item(MODE_TOP, TOP_AW'($urandom()), pick_word(), pick_word(),
                                        pick_word(), pick_word(), pick_word(), pick_word(),
                                        5'($urandom()), 1'($urandom())));
                    sent++;
                end else if (r < 14) begin
                    send_item(make_item(MODE_SIDE, TOP_AW'($urandom()), pick_word(), pick_word(),
                                        pick_word(), pick_word(), pick_word(), pick_word(),
                                        5'($urandom()), 1'($urandom())));
                    sent++;
                end else if (r < 22 || pix_ok.size() == 0) begin
                    // load a matching top and side pair for an upper-half position
                    j = $urandom_range(0, SIDE_DEPTH - 1);
                    send_item(make_item(MODE_SIDE, {1'($urandom()), SIDE_AW'(j)}, pick_word(),
                                        '0, '0, '0, '0, '0, 5'h00, 1'b0));
                    send_item(make_item(MODE_TOP, TOP_AW'(j + HALF), pick_word(), '0, '0, '0,
                                        '0, '0, 5'h00, 1'b0));
                    sent += 2;
                end else begin
                    it = make_item(MODE_PIXEL, pix_ok[$urandom_range(0, pix_ok.size() - 1)],
                                   pick_word(), pick_word(), pick_word(), pick_word(),
                                   pick_word(), pick_word(), 5'($urandom()),
                                   $urandom_range(0, 7) == 0);
                    send_item(it);
                    sent++;
                end
            end
        end
        steady = 1'b0;

        // Drain and report
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fails == 0 && texel_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### hemicube_weighted_irradiance_gather.f
+incdir+hw/rtl
hw/rtl/hwig_pkg.sv
hw/rtl/hwig_wmem.sv
hw/rtl/hwig_mac.sv
hw/rtl/hwig_accum.sv
hw/rtl/hemicube_weighted_irradiance_gather.sv
verif/tb.sv
